[hw/rtl/vftc_pkg.sv]
// shared widths, register codes and control types for the frame target calculator
`default_nettype none

package vftc_pkg;

  // time field width of the request channel
  localparam int TIME_BITS = 62;
  // working width: one bit above a time so sums of a time and an interval never wrap
  localparam int SUM_W     = TIME_BITS + 1;
  // result field width
  localparam int OUT_W     = 63;
  // configuration register width
  localparam int CFG_W     = 30;
  // configuration index width
  localparam int CFG_IDX_W = 4;
  // bit counter of the serial remainder unit
  localparam int CNT_W     = $clog2(SUM_W);

  // reset value of the frame interval register
  localparam logic [CFG_W-1:0] INTERVAL_RST = CFG_W'(16666667);

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FRAME_INTERVAL = CFG_IDX_W'(0),
    REG_LEAD_OFFSET    = CFG_IDX_W'(1)
  } vftc_reg_t;

  // effective timing derived from the configuration registers
  typedef struct packed {
    logic [CFG_W-1:0] ivl;
    logic [CFG_W-1:0] lead;
  } vftc_cfg_t;

  // control of the serial remainder unit
  typedef struct packed {
    logic start;
    logic step;
  } vftc_rem_ctl_t;

endpackage

`default_nettype wire

[hw/rtl/vftc_in_if.sv]
// request channel: timing snapshot for one frame
`default_nettype none

interface vftc_in_if;
  logic                          valid;
  logic                          ready;
  logic [vftc_pkg::TIME_BITS-1:0] now_time;
  logic [vftc_pkg::TIME_BITS-1:0] reported_vsync;
  logic [vftc_pkg::TIME_BITS-1:0] last_presented_time;
  logic [vftc_pkg::TIME_BITS-1:0] last_targeted_time;
  logic                          secondary;

  modport source (
    output valid, now_time, reported_vsync, last_presented_time, last_targeted_time,
           secondary,
    input  ready
  );

  modport sink (
    input  valid, now_time, reported_vsync, last_presented_time, last_targeted_time,
           secondary,
    output ready
  );
endinterface

`default_nettype wire

[hw/rtl/vftc_out_if.sv]
// result channel: frame start and targeted vsync
`default_nettype none

interface vftc_out_if;
  logic                       valid;
  logic                       ready;
  logic [vftc_pkg::OUT_W-1:0] frame_begin;
  logic [vftc_pkg::OUT_W-1:0] frame_end;

  modport source (
    output valid, frame_begin, frame_end,
    input  ready
  );

  modport sink (
    input  valid, frame_begin, frame_end,
    output ready
  );
endinterface

`default_nettype wire

[hw/rtl/vftc_cfg_if.sv]
// configuration write channel
`default_nettype none

interface vftc_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [vftc_pkg::CFG_IDX_W-1:0] index;
  logic [vftc_pkg::CFG_W-1:0]     data;

  modport source (
    output valid, index, data,
    input  ready
  );

  modport sink (
    input  valid, index, data,
    output ready
  );
endinterface

`default_nettype wire

[hw/rtl/vftc_cfg.sv]
// configuration registers and effective interval and lead
`default_nettype none

module vftc_cfg (
  input  logic                clk,
  input  logic                rst_n,
  vftc_cfg_if.sink            cfg_ch,
  output vftc_pkg::vftc_cfg_t eff
);

  logic [vftc_pkg::CFG_W-1:0] interval_r;
  logic [vftc_pkg::CFG_W-1:0] offset_r;
  logic [vftc_pkg::CFG_W-1:0] ivl_w;
  logic [vftc_pkg::CFG_W-1:0] lead_w;
  vftc_pkg::vftc_cfg_t        eff_r;
  logic                       wr_en;

  // writes are always taken
  assign cfg_ch.ready = 1'b1;
  assign wr_en        = cfg_ch.valid && cfg_ch.ready;

  // register file
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      interval_r <= vftc_pkg::INTERVAL_RST;
      offset_r   <= '0;
    end else if (wr_en) begin
      unique case (cfg_ch.index)
        vftc_pkg::REG_FRAME_INTERVAL: interval_r <= cfg_ch.data;
        vftc_pkg::REG_LEAD_OFFSET:    offset_r   <= cfg_ch.data;
        default: ;
      endcase
    end
  end

  // zero interval acts as one ns; zero or oversized offset becomes the full interval
  assign ivl_w  = (interval_r == '0) ? vftc_pkg::CFG_W'(1) : interval_r;
  assign lead_w = (offset_r == '0 || offset_r > ivl_w) ? ivl_w : offset_r;

  // registered copy for the datapath
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      eff_r.ivl  <= vftc_pkg::INTERVAL_RST;
      eff_r.lead <= vftc_pkg::INTERVAL_RST;
    end else begin
      eff_r.ivl  <= ivl_w;
      eff_r.lead <= lead_w;
    end
  end

  assign eff = eff_r;

endmodule

`default_nettype wire

[hw/rtl/vftc_rem.sv]
// bit-serial restoring remainder: one dividend bit per cycle while step is set, msb first
`default_nettype none

module vftc_rem (
  input  logic                       clk,
  input  vftc_pkg::vftc_rem_ctl_t    ctl,
  input  logic [vftc_pkg::SUM_W-1:0] dividend,
  input  logic [vftc_pkg::CFG_W-1:0] divisor,
  output logic [vftc_pkg::CFG_W-1:0] rem
);

  logic [vftc_pkg::SUM_W-1:0] dvd_r;
  logic [vftc_pkg::CFG_W-1:0] rem_r;
  logic [vftc_pkg::CFG_W:0]   trial_w;
  logic [vftc_pkg::CFG_W:0]   diff_w;

  // shift next dividend bit into the partial remainder and try a subtract
  assign trial_w = {rem_r, dvd_r[vftc_pkg::SUM_W-1]};
  assign diff_w  = trial_w - {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (ctl.start) begin
      dvd_r <= dividend;
      rem_r <= '0;
    end else if (ctl.step) begin
      dvd_r <= {dvd_r[vftc_pkg::SUM_W-2:0], 1'b0};
      if (trial_w >= {1'b0, divisor}) begin
        rem_r <= diff_w[vftc_pkg::CFG_W-1:0];
      end else begin
        rem_r <= trial_w[vftc_pkg::CFG_W-1:0];
      end
    end
  end

  assign rem = rem_r;

endmodule

`default_nettype wire

[hw/rtl/vsync_frame_target_calc_top.sv]
// top level of the vsync frame target calculator
//
// in_ch carries one request per frame (now, reported vsync, last presentation,
// last targeted vsync, secondary flag); out_ch returns frame_begin and
// frame_end for it; cfg_ch writes frame_interval (index 0) and the lead offset
// (index 1) and is always ready. Write configuration only between requests.
// A request passes from acceptance to out_ch.valid through PREP1 to PREP3,
// the serial pass and FIX1 to FIX4. The pass is made by two bit-serial
// remainder units that run side by side, one dividend bit per cycle over
// TIME_BITS + 1 bits: one finds the phase of now on the presentation grid,
// the other the phase of the goal past now or the reported vsync.
// in_ch.ready is high only while no request is in work, so a new request is
// accepted only once the last has left FIX4. The result sits in an output
// register; a new request is accepted while it waits, and a finished request
// holds in its last step until the register frees up when out_ch.ready is low.
// Reset (rst_n low, synchronous) restores frame_interval 16666667 ns, offset
// zero, drops any request in work and clears out_ch.valid.
`default_nettype none

module vsync_frame_target_calc_top (
  input  logic       clk,
  input  logic       rst_n,
  vftc_in_if.sink    in_ch,
  vftc_out_if.source out_ch,
  vftc_cfg_if.sink   cfg_ch
);

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_PREP1 = 9'b000000010,
    S_PREP2 = 9'b000000100,
    S_PREP3 = 9'b000001000,
    S_DIV   = 9'b000010000,
    S_FIX1  = 9'b000100000,
    S_FIX2  = 9'b001000000,
    S_FIX3  = 9'b010000000,
    S_FIX4  = 9'b100000000
  } vftc_state_t;

  vftc_state_t                    state_r;
  vftc_state_t                    state_nxt;
  logic [vftc_pkg::CNT_W-1:0]     cnt_r;

  vftc_pkg::vftc_cfg_t            cfg_eff;
  vftc_pkg::vftc_rem_ctl_t        rem_ctl;

  logic [vftc_pkg::TIME_BITS-1:0] now_r;
  logic [vftc_pkg::TIME_BITS-1:0] rep_r;
  logic [vftc_pkg::TIME_BITS-1:0] lp_r;
  logic [vftc_pkg::TIME_BITS-1:0] lt_r;
  logic                           sec_r;
  logic                           stale_r;
  logic                           fut_r;
  logic                           adv_r;
  logic [vftc_pkg::SUM_W-1:0]     g1_r;
  logic [vftc_pkg::SUM_W-1:0]     g2_r;
  logic [vftc_pkg::SUM_W-1:0]     g_r;
  logic [vftc_pkg::SUM_W-1:0]     d_r;
  logic [vftc_pkg::SUM_W-1:0]     vs_r;
  logic [vftc_pkg::SUM_W-1:0]     end_r;
  logic [vftc_pkg::CFG_W:0]       s_r;
  logic [vftc_pkg::CFG_W-1:0]     r2_r;

  logic [vftc_pkg::SUM_W-1:0]     e_w;
  logic [vftc_pkg::SUM_W-1:0]     start_w;
  logic [vftc_pkg::CFG_W-1:0]     r1_w;
  logic [vftc_pkg::CFG_W-1:0]     re_w;
  logic [vftc_pkg::CFG_W-1:0]     r1e_w;
  logic [vftc_pkg::CFG_W-1:0]     pad_w;
  logic [vftc_pkg::CFG_W:0]       s_sub_w;

  logic                           out_valid_r;
  logic [vftc_pkg::OUT_W-1:0]     out_start_r;
  logic [vftc_pkg::OUT_W-1:0]     out_end_r;

  logic                           in_accept;
  logic                           out_load;
  logic                           div_last;

  // configuration registers
  vftc_cfg u_cfg (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_ch (cfg_ch),
    .eff    (cfg_eff)
  );

  // handshakes
  assign in_ch.ready = (state_r == S_IDLE);
  assign in_accept   = in_ch.valid && in_ch.ready;
  assign out_load    = (state_r == S_FIX4) && (!out_valid_r || out_ch.ready);
  assign div_last    = (cnt_r == vftc_pkg::CNT_W'(vftc_pkg::SUM_W - 1));

  // distance from the chosen base to the goal
  assign e_w = g_r - (stale_r ? vftc_pkg::SUM_W'(now_r) : vftc_pkg::SUM_W'(rep_r));

  // remainder unit control
  assign rem_ctl.start = (state_r == S_PREP3);
  assign rem_ctl.step  = (state_r == S_DIV);

  // phase of now past the last presentation
  vftc_rem u_rem_phase (
    .clk      (clk),
    .ctl      (rem_ctl),
    .dividend (d_r),
    .divisor  (cfg_eff.ivl),
    .rem      (r1_w)
  );

  // phase of the goal past the base
  vftc_rem u_rem_goal (
    .clk      (clk),
    .ctl      (rem_ctl),
    .dividend (e_w),
    .divisor  (cfg_eff.ivl),
    .rem      (re_w)
  );

  // phase only counts when the vsync is predicted from the last presentation
  assign r1e_w   = (stale_r && !fut_r) ? r1_w : '0;
  assign s_sub_w = s_r - {1'b0, cfg_eff.ivl};
  assign pad_w   = (r2_r != '0) ? (cfg_eff.ivl - r2_r) : '0;
  assign start_w = end_r - vftc_pkg::SUM_W'(cfg_eff.lead);

  // sequencer
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:  if (in_accept) state_nxt = S_PREP1;
      S_PREP1: state_nxt = S_PREP2;
      S_PREP2: state_nxt = S_PREP3;
      S_PREP3: state_nxt = S_DIV;
      S_DIV:   if (div_last) state_nxt = S_FIX1;
      S_FIX1:  state_nxt = S_FIX2;
      S_FIX2:  state_nxt = S_FIX3;
      S_FIX3:  state_nxt = S_FIX4;
      S_FIX4:  if (out_load) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_DIV) begin
        cnt_r <= cnt_r + vftc_pkg::CNT_W'(1);
      end else begin
        cnt_r <= '0;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (in_accept) begin
      now_r <= in_ch.now_time;
      rep_r <= in_ch.reported_vsync;
      lp_r  <= in_ch.last_presented_time;
      lt_r  <= in_ch.last_targeted_time;
      sec_r <= in_ch.secondary;
    end
    // both goals and the case of the request
    if (state_r == S_PREP1) begin
      g1_r    <= vftc_pkg::SUM_W'(now_r) + vftc_pkg::SUM_W'(cfg_eff.lead);
      g2_r    <= vftc_pkg::SUM_W'(lt_r) + vftc_pkg::SUM_W'(cfg_eff.ivl >> 1);
      stale_r <= (rep_r <= now_r);
      fut_r   <= (lp_r >= now_r);
    end
    // combined goal and time since last presentation
    if (state_r == S_PREP2) begin
      g_r <= (sec_r || g1_r >= g2_r) ? g1_r : g2_r;
      d_r <= vftc_pkg::SUM_W'(now_r) - vftc_pkg::SUM_W'(lp_r);
    end
    // chosen vsync and the summed phases
    if (state_r == S_FIX1) begin
      if (stale_r) begin
        vs_r <= vftc_pkg::SUM_W'(now_r) + vftc_pkg::SUM_W'(cfg_eff.ivl)
                - vftc_pkg::SUM_W'(r1e_w);
      end else begin
        vs_r <= vftc_pkg::SUM_W'(rep_r);
      end
      s_r <= {1'b0, re_w} + {1'b0, r1e_w};
    end
    // reduce the phase sum and decide on an advance
    if (state_r == S_FIX2) begin
      r2_r  <= (s_r >= {1'b0, cfg_eff.ivl}) ? s_sub_w[vftc_pkg::CFG_W-1:0]
                                             : s_r[vftc_pkg::CFG_W-1:0];
      adv_r <= (g_r > vs_r);
    end
    // round the goal up to the vsync grid
    if (state_r == S_FIX3) begin
      end_r <= adv_r ? (g_r + vftc_pkg::SUM_W'(pad_w)) : vs_r;
    end
    // output register
    if (out_load) begin
      out_start_r <= vftc_pkg::OUT_W'(start_w);
      out_end_r   <= vftc_pkg::OUT_W'(end_r);
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.frame_begin = out_start_r;
  assign out_ch.frame_end   = out_end_r;

`ifndef SYNTHESIS
  // a frame never starts after its vsync
  a_start_before_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> (out_ch.frame_begin <= out_ch.frame_end))
    else $error("frame_begin after frame_end");

  // remainders are reduced below the interval when the serial pass ends
  a_rem_reduced: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FIX1) |-> (r1_w < cfg_eff.ivl && re_w < cfg_eff.ivl))
    else $error("remainder not below interval");

  // serial pass ends on its last working bit and moves on to FIX1
  a_div_length: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV && div_last) |=> (state_r == S_FIX1))
    else $error("remainder pass length wrong");

  // an accepted request blocks further requests until it is done
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept |=> (state_r == S_PREP1 && !in_ch.ready))
    else $error("request accepted while busy");
`endif

endmodule

`default_nettype wire

[dv/tb_vsync_frame_target_calc_top.sv]
// self-checking testbench of the vsync frame target calculator top level

module tb_vsync_frame_target_calc_top;
  import vftc_pkg::*;

  // request and result fields at the block's widths
  typedef struct packed {
    logic [TIME_BITS-1:0] now_time;
    logic [TIME_BITS-1:0] reported_vsync;
    logic [TIME_BITS-1:0] last_presented_time;
    logic [TIME_BITS-1:0] last_targeted_time;
    logic                 secondary;
  } frame_req_t;

  typedef struct packed {
    logic [OUT_W-1:0] frame_begin;
    logic [OUT_W-1:0] frame_end;
  } frame_res_t;

  // one row of the directed part: register setting, request, optional fixed result
  typedef struct packed {
    logic [CFG_W-1:0] ivl;
    logic [CFG_W-1:0] off;
    frame_req_t       req;
    logic             fixed;
    frame_res_t       res;
  } dir_row_t;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE = CFG_IDX_W'(15);
  localparam logic [TIME_BITS-1:0] T_MAX     = {TIME_BITS{1'b1}};
  localparam logic [TIME_BITS-1:0] T_ALT_A   = {(TIME_BITS/2){2'b10}};
  localparam logic [TIME_BITS-1:0] T_ALT_B   = {(TIME_BITS/2){2'b01}};
  localparam logic [CFG_W-1:0]     CFG_MAX   = {CFG_W{1'b1}};
  localparam int LATENCY     = TIME_BITS + 8;
  localparam int NUM_DIR     = 23;
  localparam int NUM_PHASES  = 10;
  localparam int PHASE_ITEMS = 65;
  localparam int QUIET_LO    = 300;
  localparam int QUIET_HI    = 420;
  localparam int HOLD_AT     = 120;
  localparam int HOLD_LEN    = 500;
  localparam int CYCLE_LIMIT = 600000;

  localparam frame_res_t NO_RES = '0;

  logic clk;
  logic rst_n;

  vftc_in_if  in_ch ();
  vftc_out_if out_ch ();
  vftc_cfg_if cfg_ch ();

  vsync_frame_target_calc_top i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  // register copies as the block holds them
  logic [CFG_W-1:0] cur_ivl;
  logic [CFG_W-1:0] cur_off;

  frame_res_t frame_target_q [$];
  int mismatch_cnt;
  int results_seen;
  int requests_sent;
  int cycle_cnt;

  // directed rows; the fixed results hold under the reset setting or plain extremes
  dir_row_t dir_rows [NUM_DIR] = '{
    '{INTERVAL_RST, 30'd0, '{62'd0, 62'd0, 62'd0, 62'd0, 1'b0},
      1'b1, '{63'd0, 63'd16666667}},
    '{INTERVAL_RST, 30'd0, '{62'd0, 62'd100000000, 62'd0, 62'd0, 1'b0},
      1'b1, '{63'd83333333, 63'd100000000}},
    '{INTERVAL_RST, 30'd0, '{T_MAX, T_MAX, T_MAX, T_MAX, 1'b0},
      1'b1, '{63'd4611686018427387903, 63'd4611686018444054570}},
    '{INTERVAL_RST, 30'd0, '{T_MAX, T_MAX, T_MAX, T_MAX, 1'b1},
      1'b1, '{63'd4611686018427387903, 63'd4611686018444054570}},
    '{INTERVAL_RST, 30'd0, '{62'd1000000000, 62'd500000000, 62'd100000000, 62'd0, 1'b0},
      1'b0, NO_RES},
    '{INTERVAL_RST, 30'd0, '{62'd50000001, 62'd0, 62'd0, 62'd0, 1'b0},
      1'b0, NO_RES},
    '{INTERVAL_RST, 30'd0, '{62'd1000000000, 62'd1000000000, 62'd1000000000, 62'd0, 1'b0},
      1'b0, NO_RES},
    '{INTERVAL_RST, 30'd0, '{62'd1000000000, 62'd2, 62'd2000000000, 62'd0, 1'b0},
      1'b0, NO_RES},
    '{INTERVAL_RST, 30'd0, '{62'd1000000000, 62'd1000000001, 62'd0, 62'd2000000000, 1'b0},
      1'b0, NO_RES},
    '{INTERVAL_RST, 30'd0, '{62'd1000000000, 62'd1000000001, 62'd0, 62'd2000000000, 1'b1},
      1'b0, NO_RES},
    '{INTERVAL_RST, 30'd0, '{T_MAX, 62'd0, 62'd0, 62'd0, 1'b0},
      1'b0, NO_RES},
    '{INTERVAL_RST, 30'd0, '{62'd0, 62'd5, 62'd0, T_MAX, 1'b0},
      1'b0, NO_RES},
    '{INTERVAL_RST, 30'd0, '{62'd0, 62'd5, 62'd0, T_MAX, 1'b1},
      1'b0, NO_RES},
    '{INTERVAL_RST, 30'd0, '{T_ALT_A, T_ALT_B, T_ALT_B, T_ALT_A, 1'b0},
      1'b0, NO_RES},
    '{INTERVAL_RST, 30'd0, '{T_ALT_B, T_ALT_A, T_ALT_A, T_ALT_B, 1'b1},
      1'b0, NO_RES},
    '{30'd0, 30'd0, '{62'd1000, 62'd0, 62'd10, 62'd0, 1'b0},
      1'b1, '{63'd1000, 63'd1001}},
    '{30'd0, 30'd5, '{62'd7, 62'd100, 62'd0, 62'd200, 1'b0},
      1'b0, NO_RES},
    '{30'd1, 30'd0, '{62'd12345, 62'd0, 62'd0, 62'd0, 1'b0},
      1'b0, NO_RES},
    '{CFG_MAX, CFG_MAX, '{T_MAX, 62'd0, 62'd0, T_MAX, 1'b0},
      1'b0, NO_RES},
    '{CFG_MAX, 30'd1, '{62'd0, 62'd0, 62'd0, 62'd0, 1'b0},
      1'b1, '{63'd1073741822, 63'd1073741823}},
    '{30'd1000000000, 30'd1000000000,
      '{62'd5000000000, 62'd0, 62'd1, 62'd6000000000, 1'b0}, 1'b0, NO_RES},
    '{30'd8333333, 30'd20000000,
      '{62'd3000000000, 62'd3000000001, 62'd2000000000, 62'd0, 1'b1}, 1'b0, NO_RES},
    '{INTERVAL_RST, 30'd4000000,
      '{62'd10000000000, 62'd0, 62'd9999000000, 62'd10016666667, 1'b0}, 1'b0, NO_RES}
  };

  // whole intervals needed to bring base up to goal
  function automatic logic [63:0] steps_needed(logic [63:0] base, logic [63:0] goal,
                                               logic [63:0] step);
    if (base >= goal) return 64'd0;
    return (goal - base + step - 64'd1) / step;
  endfunction

  // expected frame start and end for one request under the given registers
  function automatic frame_res_t calc_frame_target(frame_req_t r, logic [CFG_W-1:0] ivl_reg,
                                                   logic [CFG_W-1:0] off_reg);
    logic [63:0] now, rep, lp, lt, ivl, lead, vs, k, k2, end_t;
    frame_res_t res;
    ivl  = (ivl_reg == '0) ? 64'd1 : 64'(ivl_reg);
    lead = 64'(off_reg);
    if (lead == 64'd0 || lead > ivl) lead = ivl;
    now = 64'(r.now_time);
    rep = 64'(r.reported_vsync);
    lp  = 64'(r.last_presented_time);
    lt  = 64'(r.last_targeted_time);
    // vsync: fresh report, future presentation, or next grid point after now
    if (rep > now) vs = rep;
    else if (lp >= now) vs = now + ivl;
    else vs = lp + ivl * ((now - lp) / ivl + 64'd1);
    k = steps_needed(vs, now + lead, ivl);
    if (!r.secondary) begin
      k2 = steps_needed(vs, lt + ivl / 64'd2, ivl);
      if (k2 > k) k = k2;
    end
    end_t = vs + k * ivl;
    res.frame_end   = end_t[OUT_W-1:0];
    res.frame_begin = OUT_W'(end_t - lead);
    return res;
  endfunction

  // random value in [0, m]
  function automatic logic [63:0] rnd_upto(logic [63:0] m);
    logic [63:0] raw;
    raw = {$urandom, $urandom};
    if (m == '1) return raw;
    return raw % (m + 64'd1);
  endfunction

  // random request: mostly timing snapshots around a live vsync grid, some raw noise
  function automatic frame_req_t make_request(logic [CFG_W-1:0] ivl_reg);
    logic [63:0] ivl, now, rep, lp, lt;
    frame_req_t r;
    ivl = (ivl_reg == '0) ? 64'd1 : 64'(ivl_reg);
    if ($urandom_range(99) < 25) begin
      r.now_time            = TIME_BITS'({$urandom, $urandom});
      r.reported_vsync      = TIME_BITS'({$urandom, $urandom});
      r.last_presented_time = TIME_BITS'({$urandom, $urandom});
      r.last_targeted_time  = TIME_BITS'({$urandom, $urandom});
      r.secondary           = 1'($urandom_range(1));
      return r;
    end
    case ($urandom_range(2))
      0:       now = 64'($urandom);
      1:       now = 64'(TIME_BITS'({$urandom, $urandom}));
      default: now = 64'(T_MAX) - rnd_upto(8 * ivl);
    endcase
    case ($urandom_range(3))
      0:       rep = now + 64'd1 + rnd_upto(3 * ivl);
      1:       rep = now - rnd_upto(2 * ivl);
      2:       rep = now;
      default: rep = {$urandom, $urandom};
    endcase
    case ($urandom_range(3))
      0:       lp = now - rnd_upto(6 * ivl);
      1:       lp = now + rnd_upto(ivl);
      2:       lp = now;
      default: lp = {$urandom, $urandom};
    endcase
    case ($urandom_range(3))
      0:       lt = now + rnd_upto(4 * ivl) - rnd_upto(2 * ivl);
      1:       lt = rep;
      2:       lt = rep + ivl;
      default: lt = {$urandom, $urandom};
    endcase
    r.now_time            = TIME_BITS'(now);
    r.reported_vsync      = TIME_BITS'(rep);
    r.last_presented_time = TIME_BITS'(lp);
    r.last_targeted_time  = TIME_BITS'(lt);
    r.secondary           = ($urandom_range(3) == 0);
    return r;
  endfunction

  // offer one request transaction, at times with a random gap ahead of it
  task automatic send_request(frame_req_t r, logic fixed, frame_res_t fixed_res);
    bool_gap: begin end
    if (!(requests_sent >= QUIET_LO && requests_sent < QUIET_HI) &&
        $urandom_range(99) < 14) begin
      in_ch.valid <= 1'b0;
      if ($urandom_range(3) == 0) repeat ($urandom_range(1, 90)) @(posedge clk);
      else repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_ch.valid               <= 1'b1;
    in_ch.now_time            <= r.now_time;
    in_ch.reported_vsync      <= r.reported_vsync;
    in_ch.last_presented_time <= r.last_presented_time;
    in_ch.last_targeted_time  <= r.last_targeted_time;
    in_ch.secondary           <= r.secondary;
    do @(posedge clk); while (!in_ch.ready);
    frame_target_q.insert(frame_target_q.size(),
                          fixed ? fixed_res : calc_frame_target(r, cur_ivl, cur_off));
    requests_sent++;
  endtask

  // stop offering and wait until every expected result has come back
  task automatic drain_results();
    in_ch.valid <= 1'b0;
    while (frame_target_q.size() != 0) @(posedge clk);
  endtask

  // write both registers back to back, optionally an unused index after them
  task automatic apply_config(logic [CFG_W-1:0] ivl, logic [CFG_W-1:0] off, logic spare);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= REG_FRAME_INTERVAL;
    cfg_ch.data  <= ivl;
    do @(posedge clk); while (!cfg_ch.ready);
    cur_ivl = ivl;
    cfg_ch.index <= REG_LEAD_OFFSET;
    cfg_ch.data  <= off;
    do @(posedge clk); while (!cfg_ch.ready);
    cur_off = off;
    if (spare) begin
      cfg_ch.index <= REG_SPARE;
      cfg_ch.data  <= CFG_W'($urandom);
      do @(posedge clk); while (!cfg_ch.ready);
    end
    cfg_ch.valid <= 1'b0;
  endtask

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // watchdog
  initial begin
    cycle_cnt = 0;
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("vsync_frame_target_calc_top verification failed");
    $finish;
  end

  // result side: check each result transaction, then pick the next ready
  initial begin : result_side
    int hold_left;
    bit hold_done;
    frame_res_t want;
    hold_left    = 0;
    hold_done    = 1'b0;
    mismatch_cnt = 0;
    results_seen = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_ch.valid && out_ch.ready) begin
        results_seen++;
        if (frame_target_q.size() == 0) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10)
            $display("unexpected result: start %0d end %0d",
                     out_ch.frame_begin, out_ch.frame_end);
        end else begin
          want = frame_target_q.pop_front();
          if (out_ch.frame_begin !== want.frame_begin ||
              out_ch.frame_end !== want.frame_end) begin
            mismatch_cnt++;
            if (mismatch_cnt <= 10)
              $display("result %0d mismatch: start exp %0d got %0d, end exp %0d got %0d",
                       results_seen, want.frame_begin, out_ch.frame_begin,
                       want.frame_end, out_ch.frame_end);
          end
        end
      end
      // long hold-off once, a quiet window, random stalls elsewhere
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else if (!hold_done && results_seen == HOLD_AT) begin
        hold_done = 1'b1;
        hold_left = HOLD_LEN - 1;
        out_ch.ready <= 1'b0;
      end else if (results_seen >= QUIET_LO && results_seen < QUIET_HI) begin
        out_ch.ready <= 1'b1;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= 14);
      end
    end
  end

  // request side: reset, directed rows, then random phases over several settings
  initial begin : request_side
    logic [CFG_W-1:0] nivl;
    logic [CFG_W-1:0] noff;
    logic spare;
    rst_n                     = 1'b0;
    in_ch.valid               = 1'b0;
    in_ch.now_time            = '0;
    in_ch.reported_vsync      = '0;
    in_ch.last_presented_time = '0;
    in_ch.last_targeted_time  = '0;
    in_ch.secondary           = 1'b0;
    cfg_ch.valid              = 1'b0;
    cfg_ch.index              = REG_FRAME_INTERVAL;
    cfg_ch.data               = '0;
    cur_ivl                   = INTERVAL_RST;
    cur_off                   = '0;
    requests_sent             = 0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // directed rows, register changes only with the block drained
    for (int i = 0; i < NUM_DIR; i++) begin
      if (dir_rows[i].ivl != cur_ivl || dir_rows[i].off != cur_off) begin
        drain_results();
        apply_config(dir_rows[i].ivl, dir_rows[i].off, 1'b0);
      end
      send_request(dir_rows[i].req, dir_rows[i].fixed, dir_rows[i].res);
    end

    // random phases
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      spare = 1'b0;
      case (ph)
        0: begin nivl = INTERVAL_RST;   noff = '0;             end
        1: begin nivl = 30'd1;          noff = '0;             end
        2: begin nivl = '0;             noff = '0;             end
        3: begin nivl = CFG_MAX;        noff = CFG_MAX; spare = 1'b1; end
        4: begin nivl = 30'd1000000000; noff = 30'd1;          end
        5: begin nivl = 30'd8333333;    noff = 30'd20000000;   end
        6: begin nivl = INTERVAL_RST;   noff = INTERVAL_RST;   end
        7: begin
          nivl  = CFG_W'($urandom);
          noff  = CFG_W'($urandom);
          spare = 1'b1;
        end
        8: begin
          nivl = CFG_W'($urandom_range(2, 1000));
          noff = CFG_W'($urandom_range(0, 2000));
        end
        default: begin nivl = INTERVAL_RST; noff = 30'd4000000; end
      endcase
      drain_results();
      apply_config(nivl, noff, spare);
      for (int n = 0; n < PHASE_ITEMS; n++)
        send_request(make_request(cur_ivl), 1'b0, NO_RES);
    end

    // wait out the last results and a little more for anything stray
    drain_results();
    repeat (2 * LATENCY) @(posedge clk);
    if (mismatch_cnt == 0 && frame_target_q.size() == 0) begin
      $display("vsync_frame_target_calc_top verification clean");
    end else begin
      $display("vsync_frame_target_calc_top verification failed");
    end
    $finish;
  end

endmodule
